### hw/rtl/odd_harmonic_square_synth_top_assert.svh
// Assertion macros shared by the synthesizer's RTL modules.
`ifndef ODD_HARMONIC_SQUARE_SYNTH_TOP_ASSERT_SVH
`define ODD_HARMONIC_SQUARE_SYNTH_TOP_ASSERT_SVH

// Checks a property on every clock edge outside of reset.
`define OHSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies an expression in the next one.
`define OHSS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) else $error(msg);

`endif

### hw/rtl/ohss_pkg.sv
// Types, constants and table functions of the odd harmonic square synthesizer.
`timescale 1ns / 1ps

package ohss_pkg;

  localparam int unsigned MaxHarmonic   = 9;
  localparam int unsigned SineTableBits = 10;
  localparam int unsigned QuarterBits   = SineTableBits - 2;
  localparam int unsigned QuarterLen    = 1 << QuarterBits;
  localparam int unsigned QueueDepth    = 2;

  localparam logic [63:0] HalfPiQ30      = 64'd1686629713;
  localparam logic [31:0] PhaseStepReset = 32'd42852281;
  localparam logic [14:0] AmplitudeReset = 15'd20000;
  localparam logic [3:0]  HighestReset   = 4'd9;

  typedef enum logic [1:0] {
    RegPhaseStep       = 2'd0,
    RegAmplitude       = 2'd1,
    RegHighestHarmonic = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkRun,
    BkMulLo,
    BkMulHi,
    BkDone
  } back_state_e;

  typedef struct packed {
    logic [31:0] phase;
    logic [3:0]  nharm;
    logic [14:0] amplitude;
  } job_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               clipped;
  } result_t;

  // Coefficient (4/pi)/n in Q1.16 for the odd harmonic n = 2 * idx + 1.
  function automatic logic [16:0] harmonic_coef(input logic [2:0] idx);
    logic [16:0] c;
    unique case (idx)
      3'd0: c = 17'd83443;
      3'd1: c = 17'd27814;
      3'd2: c = 17'd16689;
      3'd3: c = 17'd11920;
      3'd4: c = 17'd9271;
      3'd5: c = 17'd7586;
      3'd6: c = 17'd6419;
      3'd7: c = 17'd5563;
    endcase
    return c;
  endfunction

  // Quarter-wave sine entry k in Q0.15, from a Taylor series evaluated in Q30.
  function automatic logic [14:0] quarter_sine(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      q15;
    x    = (64'(k) * HalfPiQ30) >> QuarterBits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    q15 = (sum + 64'sd16384) >>> 15;
    if (q15 > 64'sd32767) begin
      q15 = 64'sd32767;
    end
    return 15'(q15);
  endfunction

endpackage

### hw/rtl/odd_harmonic_square_synth_top.sv
// Top level of the odd harmonic square-wave synthesizer.
// The back end works on one sample at a time, with one table lookup and one coefficient
// multiply per odd harmonic included (up to 5) plus two scaling multiplies; the next request
// is taken from the queue once the current sample has been written out.
// Reset (rst_ni low, asynchronous) empties both queues, clears the phase to zero and loads
// the default step, amplitude and harmonic limit.
`timescale 1ns / 1ps

module odd_harmonic_square_synth_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic               restart_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] sample_o,
  output logic               clipped_o
);
  import ohss_pkg::*;

  job_t    job_in, job_out;
  result_t res_in, res_out;
  logic    job_wr, job_rd, job_empty;
  logic    out_wr, out_full;

  ohss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .restart_i   (restart_i),
    .full_i      (full),
    .job_wr_o    (job_wr),
    .job_o       (job_in)
  );

  ohss_fifo #(
    .Width ($bits(job_t))
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_wr),
    .wdata_i (job_in),
    .full_o  (full),
    .rd_i    (job_rd),
    .rdata_o (job_out),
    .empty_o (job_empty)
  );

  ohss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_rd_o    (job_rd),
    .out_full_i  (out_full),
    .out_wr_o    (out_wr),
    .result_o    (res_in)
  );

  ohss_fifo #(
    .Width ($bits(result_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (out_wr),
    .wdata_i (res_in),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign sample_o  = res_out.sample;
  assign clipped_o = res_out.clipped;

endmodule

### hw/rtl/ohss_fifo.sv
// Small register queue used between the front end, the back end and the result port.
`timescale 1ns / 1ps
`include "odd_harmonic_square_synth_top_assert.svh"

module ohss_fifo #(
  parameter int unsigned Width = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  import ohss_pkg::*;

  localparam int unsigned Depth = QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr, rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr      = wr_i && !full_o;
  assign rd      = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `OHSS_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "Queue count exceeds its depth.")
  `OHSS_ASSERT_NEXT(a_cnt_up, wr && !rd, cnt_q == $past(cnt_q) + 1'b1, "Write lost.")
  `OHSS_ASSERT_NEXT(a_cnt_down, rd && !wr, cnt_q == $past(cnt_q) - 1'b1, "Read lost.")

endmodule

### hw/rtl/ohss_front.sv
// Front end: configuration registers, phase accumulator and request intake.
`timescale 1ns / 1ps

module ohss_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          push_i,
  input  logic          restart_i,
  input  logic          full_i,
  output logic          job_wr_o,
  output ohss_pkg::job_t job_o
);
  import ohss_pkg::*;

  logic [31:0] phase_step_q, phase_step_d;
  logic [14:0] amplitude_q, amplitude_d;
  logic [3:0]  highest_q, highest_d;
  logic [31:0] phase_acc_q, phase_acc_d;
  logic [31:0] base;
  logic [3:0]  limit;
  logic        accept;

  assign accept   = push_i && !full_i;
  assign job_wr_o = accept;
  assign base     = restart_i ? '0 : phase_acc_q;
  assign limit    = (highest_q > 4'(MaxHarmonic)) ? 4'(MaxHarmonic) : highest_q;

  always_comb begin
    job_o.phase     = base;
    job_o.nharm     = 4'((5'(limit) + 5'd1) >> 1);
    job_o.amplitude = amplitude_q;
  end

  always_comb begin
    phase_step_d = phase_step_q;
    amplitude_d  = amplitude_q;
    highest_d    = highest_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPhaseStep:       phase_step_d = cfg_wdata_i;
        RegAmplitude:       amplitude_d  = cfg_wdata_i[14:0];
        RegHighestHarmonic: highest_d    = cfg_wdata_i[3:0];
        default:            ;
      endcase
    end
    phase_acc_d = accept ? base + phase_step_q : phase_acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PhaseStepReset;
      amplitude_q  <= AmplitudeReset;
      highest_q    <= HighestReset;
      phase_acc_q  <= '0;
    end else begin
      phase_step_q <= phase_step_d;
      amplitude_q  <= amplitude_d;
      highest_q    <= highest_d;
      phase_acc_q  <= phase_acc_d;
    end
  end

endmodule

### hw/rtl/ohss_back.sv
// Back end: harmonic sum over a sine table, amplitude scaling and saturation.
`timescale 1ns / 1ps
`include "odd_harmonic_square_synth_top_assert.svh"

module ohss_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_empty_i,
  input  ohss_pkg::job_t   job_i,
  output logic             job_rd_o,
  input  logic             out_full_i,
  output logic             out_wr_o,
  output ohss_pkg::result_t result_o
);
  import ohss_pkg::*;

  logic [14:0] sine_rom [QuarterLen];

  for (genvar g = 0; g < QuarterLen; g++) begin : g_rom
    localparam logic [14:0] Entry = quarter_sine(g + 1);
    assign sine_rom[g] = Entry;
  end

  back_state_e state_q, state_d;

  logic [31:0]        ph_q;
  logic [31:0]        step2_q;
  logic [14:0]        amp_q;
  logic [3:0]         nharm_q;
  logic [3:0]         issue_cnt_q;
  logic signed [15:0] sin_q;
  logic [16:0]        coef_q;
  logic               sin_v_q;
  logic signed [33:0] prod_q;
  logic               prod_v_q;
  logic signed [33:0] acc_q;
  logic [33:0]        plo_q;
  logic signed [48:0] s_q;

  logic                     load, issue;
  logic [SineTableBits-1:0] tab_idx;
  logic [1:0]               quad;
  logic [QuarterBits-1:0]   off;
  logic [QuarterBits-1:0]   rom_addr;
  logic [14:0]              mag;
  logic signed [15:0]       sine;
  logic signed [31:0]       phi;
  logic signed [48:0]       s_d;
  logic signed [17:0]       q;

  assign tab_idx  = ph_q[31 -: SineTableBits];
  assign quad     = tab_idx[SineTableBits-1 -: 2];
  assign off      = tab_idx[QuarterBits-1:0];
  assign rom_addr = quad[0] ? ~off : off - 1'b1;
  assign mag      = (!quad[0] && (off == '0)) ? '0 : sine_rom[rom_addr];
  assign sine     = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign phi = $signed({{16{acc_q[33]}}, acc_q[33:18]}) * $signed({17'b0, amp_q});
  assign s_d = $signed({phi[30:0], 18'b0}) + $signed({15'b0, plo_q});
  assign q   = s_q[48:31];

  always_comb begin
    if (q > 18'sd32767) begin
      result_o.sample  = 16'sh7FFF;
      result_o.clipped = 1'b1;
    end else if (q < -18'sd32768) begin
      result_o.sample  = -16'sh8000;
      result_o.clipped = 1'b1;
    end else begin
      result_o.sample  = q[15:0];
      result_o.clipped = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    out_wr_o = 1'b0;
    load     = 1'b0;
    issue    = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!job_empty_i) begin
          load    = 1'b1;
          state_d = BkRun;
        end
      end
      BkRun: begin
        issue = (issue_cnt_q < nharm_q);
        if (!issue && !sin_v_q) begin
          state_d = BkMulLo;
        end
      end
      BkMulLo: state_d = BkMulHi;
      BkMulHi: state_d = BkDone;
      BkDone: begin
        if (!out_full_i) begin
          out_wr_o = 1'b1;
          if (!job_empty_i) begin
            load    = 1'b1;
            state_d = BkRun;
          end else begin
            state_d = BkIdle;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  assign job_rd_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      issue_cnt_q <= '0;
      sin_v_q     <= 1'b0;
      prod_v_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      sin_v_q  <= issue;
      prod_v_q <= sin_v_q;
      if (load) begin
        issue_cnt_q <= '0;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ph_q    <= job_i.phase;
      step2_q <= {job_i.phase[30:0], 1'b0};
      amp_q   <= job_i.amplitude;
      nharm_q <= job_i.nharm;
      acc_q   <= '0;
    end else begin
      if (issue) begin
        ph_q <= ph_q + step2_q;
      end
      if (prod_v_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
    if (issue) begin
      sin_q  <= sine;
      coef_q <= harmonic_coef(issue_cnt_q[2:0]);
    end
    if (sin_v_q) begin
      prod_q <= $signed({17'b0, coef_q}) * $signed({{18{sin_q[15]}}, sin_q});
    end
    if (state_q == BkMulLo) begin
      plo_q <= 34'(acc_q[17:0]) * 34'(amp_q) + (acc_q[33] ? 34'h07FFFFFFF : 34'h0);
    end
    if (state_q == BkMulHi) begin
      s_q <= s_d;
    end
  end

  `OHSS_ASSERT(a_pipe_idle, (state_q != BkRun) |-> !(sin_v_q || prod_v_q), "Pipe busy outside run.")
  `OHSS_ASSERT(a_issue_bound, (state_q == BkRun) |-> (issue_cnt_q <= nharm_q), "Too many harmonics.")
  `OHSS_ASSERT_NEXT(a_mul_seq, state_q == BkMulLo, state_q == BkMulHi, "Scaling steps skipped.")

endmodule
